FILE: rtl/core/epr_pkg.sv
`default_nettype none
package epr_pkg;

	localparam int unsigned AngleWidth = 9;
	localparam int unsigned CoefFrac   = 14;
	localparam int unsigned CoefWidth  = CoefFrac + 2;
	localparam int unsigned CoordWidth = 24;
	localparam int unsigned TabDepth   = 91;

	localparam logic [1:0] RegAngleX = 2'd0;
	localparam logic [1:0] RegAngleY = 2'd1;
	localparam logic [1:0] RegAngleZ = 2'd2;

	typedef struct packed {
		logic signed [CoordWidth-1:0] in_x;
		logic signed [CoordWidth-1:0] in_y;
		logic signed [CoordWidth-1:0] in_z;
	} in_word_t;

	typedef struct packed {
		logic signed [CoordWidth-1:0] out_x;
		logic signed [CoordWidth-1:0] out_y;
		logic signed [CoordWidth-1:0] out_z;
	} out_word_t;

	typedef logic signed [CoefWidth-1:0] coef_t;

	// sin(k deg) in Q2.14, k = 0..90
	function automatic logic [14:0] sin_tab(input logic [6:0] k);
		logic [14:0] t [0:90];
		t = '{15'd0,15'd286,15'd572,15'd857,15'd1143,15'd1428,15'd1713,15'd1997,
			15'd2280,15'd2563,15'd2845,15'd3126,15'd3406,15'd3686,15'd3964,15'd4240,
			15'd4516,15'd4790,15'd5063,15'd5334,15'd5604,15'd5872,15'd6138,15'd6402,
			15'd6664,15'd6924,15'd7182,15'd7438,15'd7692,15'd7943,15'd8192,15'd8438,
			15'd8682,15'd8923,15'd9162,15'd9397,15'd9630,15'd9860,15'd10087,15'd10311,
			15'd10531,15'd10749,15'd10963,15'd11174,15'd11381,15'd11585,15'd11786,
			15'd11982,15'd12176,15'd12365,15'd12551,15'd12733,15'd12911,15'd13085,
			15'd13255,15'd13421,15'd13583,15'd13741,15'd13894,15'd14044,15'd14189,
			15'd14330,15'd14466,15'd14598,15'd14726,15'd14849,15'd14968,15'd15082,
			15'd15191,15'd15296,15'd15396,15'd15491,15'd15582,15'd15668,15'd15749,
			15'd15826,15'd15897,15'd15964,15'd16026,15'd16083,15'd16135,15'd16182,
			15'd16225,15'd16262,15'd16294,15'd16322,15'd16344,15'd16362,15'd16374,
			15'd16382,15'd16384};
		if (k > 7'd90)
			return 15'd0;
		return t[k];
	endfunction

	// sine of a reduced angle 0..449 (cos callers add 90)
	function automatic coef_t sin_deg(input logic [8:0] a);
		logic [8:0] r;
		logic [8:0] i;
		logic       neg;
		r = (a >= 9'd360) ? a - 9'd360 : a;
		neg = 1'b0;
		if (r <= 9'd90) i = r;
		else if (r <= 9'd180) i = 9'd180 - r;
		else if (r <= 9'd270) begin i = r - 9'd180; neg = 1'b1; end
		else begin i = 9'd360 - r; neg = 1'b1; end
		return neg ? -coef_t'({1'b0, sin_tab(i[6:0])}) : coef_t'({1'b0, sin_tab(i[6:0])});
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/epr_coef.sv
`default_nettype none
// Rebuilds R after an angle write: trig lookup, Rz*Ry, then *Rx, then rounding, one step a stage.
module epr_coef (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [epr_pkg::AngleWidth-1:0]      cfg_data,
	output epr_pkg::coef_t                           coef [9]
);
	localparam int unsigned F = epr_pkg::CoefFrac;
	localparam int unsigned W = epr_pkg::CoefWidth;

	logic [8:0] ax_q, ay_q, az_q;
	logic [3:0] go_q;
	logic       wr_hit;

	// reduce 0..511 mod 360
	function automatic logic [8:0] red(input logic [8:0] a);
		return (a >= 9'd360) ? a - 9'd360 : a;
	endfunction

	assign wr_hit = cfg_we && (cfg_index inside {epr_pkg::RegAngleX, epr_pkg::RegAngleY,
		epr_pkg::RegAngleZ});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; az_q <= '0;
			go_q <= '0;
		end else begin
			go_q <= {go_q[2:0], wr_hit};
			if (cfg_we) begin
				unique case (cfg_index)
					epr_pkg::RegAngleX: ax_q <= red(cfg_data);
					epr_pkg::RegAngleY: ay_q <= red(cfg_data);
					epr_pkg::RegAngleZ: az_q <= red(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// stage 1: sin/cos
	epr_pkg::coef_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	always_ff @(posedge clk) begin
		sx_s1 <= epr_pkg::sin_deg(ax_q); cx_s1 <= epr_pkg::sin_deg(ax_q + 9'd90);
		sy_s1 <= epr_pkg::sin_deg(ay_q); cy_s1 <= epr_pkg::sin_deg(ay_q + 9'd90);
		sz_s1 <= epr_pkg::sin_deg(az_q); cz_s1 <= epr_pkg::sin_deg(az_q + 9'd90);
	end

	// stage 2: ZY = Rz*Ry at 2F fraction bits
	localparam int unsigned ZW = 2 * W;
	logic signed [ZW-1:0] zy_s2 [9];
	logic signed [W-1:0]  cx_s2, sx_s2;
	always_ff @(posedge clk) begin
		zy_s2[0] <= ZW'(cz_s1) * ZW'(cy_s1);
		zy_s2[1] <= -(ZW'(sz_s1) <<< F);
		zy_s2[2] <= ZW'(cz_s1) * ZW'(sy_s1);
		zy_s2[3] <= ZW'(sz_s1) * ZW'(cy_s1);
		zy_s2[4] <= ZW'(cz_s1) <<< F;
		zy_s2[5] <= ZW'(sz_s1) * ZW'(sy_s1);
		zy_s2[6] <= -(ZW'(sy_s1) <<< F);
		zy_s2[7] <= '0;
		zy_s2[8] <= ZW'(cy_s1) <<< F;
		cx_s2 <= cx_s1; sx_s2 <= sx_s1;
	end

	// stage 3: products with Rx at 3F
	localparam int unsigned PW = 3 * W + 1;
	logic signed [PW-1:0] p_s3 [9];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s3[3*i]   <= PW'(zy_s2[3*i]) <<< F;
			p_s3[3*i+1] <= PW'(zy_s2[3*i+1]) * PW'(cx_s2) + PW'(zy_s2[3*i+2]) * PW'(sx_s2);
			p_s3[3*i+2] <= PW'(zy_s2[3*i+2]) * PW'(cx_s2) - PW'(zy_s2[3*i+1]) * PW'(sx_s2);
		end
	end

	// stage 4: round, hold as state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				coef[i] <= (i % 4 == 0) ? W'(1 << F) : '0;
		end else if (go_q[3]) begin
			for (int i = 0; i < 9; i++)
				coef[i] <= W'((p_s3[i] + (PW'(1) <<< (2*F-1))) >>> (2*F));
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/epr_mac.sv
`default_nettype none
// Point pipeline: products, row sums, round/saturate, output register.
module epr_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire epr_pkg::coef_t    coef [9],
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire epr_pkg::in_word_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output epr_pkg::out_word_t     out_data
);
	localparam int unsigned C  = epr_pkg::CoordWidth;
	localparam int unsigned F  = epr_pkg::CoefFrac;
	localparam int unsigned MW = C + epr_pkg::CoefWidth;
	localparam int unsigned SW = MW + 2;

	logic v_s1, v_s2, v_s3;
	logic adv;
	assign adv = !v_s3 || out_ready;
	assign in_ready = adv;

	logic signed [MW-1:0] m_s1 [9];
	logic signed [SW-1:0] s_s2 [3];
	epr_pkg::out_word_t   o_s3;
	logic signed [C-1:0]  pin [3];
	assign pin[0] = in_data.in_x;
	assign pin[1] = in_data.in_y;
	assign pin[2] = in_data.in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	function automatic logic signed [C-1:0] sat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] r;
		r = (s + (SW'(1) <<< (F-1))) >>> F;
		if (r > SW'((1 << (C-1)) - 1)) return {1'b0, {(C-1){1'b1}}};
		if (r < -(SW'(1) <<< (C-1))) return {1'b1, {(C-1){1'b0}}};
		return r[C-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++)
				m_s1[i] <= MW'(coef[i]) * MW'(pin[i % 3]);
			for (int i = 0; i < 3; i++)
				s_s2[i] <= SW'(m_s1[3*i]) + SW'(m_s1[3*i+1]) + SW'(m_s1[3*i+2]);
			o_s3.out_x <= sat(s_s2[0]);
			o_s3.out_y <= sat(s_s2[1]);
			o_s3.out_z <= sat(s_s2[2]);
		end
	end

	assign out_valid = v_s3;
	assign out_data  = o_s3;
endmodule
`default_nettype wire

FILE: rtl/core/euler_point_rotator_top.sv
`default_nettype none
// ZYX Euler point rotator. Points (Q12.12) stream in at one word per cycle unless stalled
// and come out rotated, rounded and saturated; the three-stage multiply/sum/round
// pipeline stalls as a whole on out_ready. Angle writes (degrees, reduced mod 360) rebuild
// the matrix via trig, Rz*Ry, *Rx and round stages; write only while no word is in flight.
module euler_point_rotator_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [epr_pkg::AngleWidth-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire epr_pkg::in_word_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output epr_pkg::out_word_t                  out_data
);
	epr_pkg::coef_t coef [9];

	epr_coef u_coef (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .coef);
	epr_mac u_mac (.clk, .arst_n, .coef, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire

FILE: rtl/core/epr_checker.sv
`default_nettype none
module epr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("word dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("stalled with empty output");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("word lost in pipeline");
endmodule

bind euler_point_rotator_top epr_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready);
`default_nettype wire
